// ----- src/mr2_pkg.sv -----
// shared constants and types of the 2x2 mipmap reducer
`default_nettype none
package mr2_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

	localparam int PIX_W    = 32;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int LINE_AW  = $clog2(LINE_DEPTH);

	// register field widths
	localparam int SRC_W_W  = 12;
	localparam int SRC_H_W  = 13;
	localparam int DST_W_W  = 11;
	localparam int DST_H_W  = 12;
	localparam int MODE_W   = 2;
	localparam int ALPHA_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CUTOFF = 3'd5;

	// filter modes
	localparam logic [MODE_W-1:0] FILT_BOX    = 2'd0;
	localparam logic [MODE_W-1:0] FILT_MODE   = 2'd1;
	localparam logic [MODE_W-1:0] FILT_CUTOUT = 2'd2;

	// four samples of a block: top-left, top-right, bottom-left, bottom-right
	typedef logic [3:0][PIX_W-1:0] quad_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ALPHA_W-1:0] cutoff;
	} filt_cfg_t;

endpackage
`default_nettype wire

// ----- src/mr2_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module mr2_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/mr2_filter.sv -----
// 2x2 block filter: box average, most frequent value, alpha cutout
`default_nettype none
module mr2_filter (
	input  wire mr2_pkg::quad_t             samples,
	input  wire mr2_pkg::filt_cfg_t         cfg,
	output      logic [mr2_pkg::PIX_W-1:0] result
);
	import mr2_pkg::*;

	logic [PIX_W-1:0] box_v;
	logic [PIX_W-1:0] mode_v;
	logic [PIX_W-1:0] cut_v;

	// floored per-channel average
	always_comb begin
		logic [9:0] sum;
		box_v = '0;
		for (int c = 0; c < 4; c++) begin
			sum = 10'(samples[0][c*8 +: 8]) + 10'(samples[1][c*8 +: 8])
				+ 10'(samples[2][c*8 +: 8]) + 10'(samples[3][c*8 +: 8]);
			box_v[c*8 +: 8] = sum[9:2];
		end
	end

	// most frequent value, earliest sample wins ties
	always_comb begin
		logic e01, e02, e03, e12, e13, e23;
		logic [2:0] n0, n1, n2;
		logic [2:0] best_n;
		logic [1:0] best;
		e01 = samples[0] == samples[1];
		e02 = samples[0] == samples[2];
		e03 = samples[0] == samples[3];
		e12 = samples[1] == samples[2];
		e13 = samples[1] == samples[3];
		e23 = samples[2] == samples[3];
		n0 = 3'd1 + {2'b0, e01} + {2'b0, e02} + {2'b0, e03};
		n1 = 3'd1 + {2'b0, e12} + {2'b0, e13};
		n2 = 3'd1 + {2'b0, e23};
		best = 2'd0;
		best_n = n0;
		if (n1 > best_n) begin
			best = 2'd1;
			best_n = n1;
		end
		if (n2 > best_n) begin
			best = 2'd2;
		end
		mode_v = samples[best];
	end

	// alpha cutout
	always_comb begin
		logic [7:0] best_a;
		logic [1:0] best;
		logic       opaque;
		best_a = samples[0][31:24];
		best = 2'd0;
		opaque = samples[0][31:24] >= cfg.cutoff;
		for (int i = 1; i < 4; i++) begin
			if (samples[i][31:24] > best_a) begin
				best_a = samples[i][31:24];
				best = 2'(i);
			end
			if (samples[i][31:24] >= cfg.cutoff) begin
				opaque = 1'b1;
			end
		end
		cut_v = opaque ? {8'hFF, samples[best][23:0]} : '0;
	end

	always_comb begin
		unique case (cfg.mode)
			FILT_MODE:   result = mode_v;
			FILT_CUTOUT: result = cut_v;
			default:     result = box_v;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/mip_reduce_2x2.sv -----
// Streaming 2x2 mipmap reducer for RGBA images, one source pixel per item.
// Source pixels enter on the s_ channel in raster order; for each completed
// 2x2 block that lies inside the destination size one destination pixel
// leaves on the m_ channel, with m_tlast on the last pixel of a row and
// m_tuser on the last pixel of the image. Odd edges repeat the last column
// or row. The top pair of every block waits in a line ram of 1024 entries,
// written on even rows and read back on odd rows.
// Path: the edge that accepts the last source item of a block does the line ram
// read and the read stage load; the filter then feeds the output register once
// it is free. Throughput: one item per cycle when the receiver does not stall;
// each pair of columns makes at most one line ram access.
// Reset: counters at image start, registers at their defaults; the line ram
// needs no clearing since each entry is written before it is read.
// A stalled receiver holds the output register; one more result waits in
// the read stage, after which s_tready drops until m_tready returns.
// Writing any geometry register restarts the frame.
`default_nettype none
module mip_reduce_2x2 (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [31:0]                    s_tdata,   // pixel_rgba
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [31:0]                    m_tdata,   // result_rgba
	output      logic                           m_tlast,   // row_end
	output      logic                           m_tuser,   // image_end
	input  wire logic                           cfg_we,
	input  wire logic [mr2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mr2_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mr2_pkg::*;

	logic [SRC_W_W-1:0] src_width_q;
	logic [SRC_H_W-1:0] src_height_q;
	logic [DST_W_W-1:0] dst_width_q;
	logic [DST_H_W-1:0] dst_height_q;
	filt_cfg_t          fcfg_q;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PIX_W-1:0]   held_q;

	// effective geometry
	logic [SRC_W_W-1:0] ew;
	logic [SRC_H_W-1:0] eh;
	logic [DST_W_W-1:0] half_w, dw;
	logic [DST_H_W-1:0] half_h, dh;

	always_comb begin
		if (src_width_q == '0) ew = SRC_W_W'(1);
		else if (src_width_q > SRC_W_W'(MAX_WIDTH)) ew = SRC_W_W'(MAX_WIDTH);
		else ew = src_width_q;
		if (src_height_q == '0) eh = SRC_H_W'(1);
		else if (src_height_q > SRC_H_W'(MAX_HEIGHT)) eh = SRC_H_W'(MAX_HEIGHT);
		else eh = src_height_q;
		half_w = DST_W_W'((ew + SRC_W_W'(1)) >> 1);
		half_h = DST_H_W'((eh + SRC_H_W'(1)) >> 1);
		if (dst_width_q == '0) dw = DST_W_W'(1);
		else if (dst_width_q > half_w) dw = half_w;
		else dw = dst_width_q;
		if (dst_height_q == '0) dh = DST_H_W'(1);
		else if (dst_height_q > half_h) dh = half_h;
		else dh = dst_height_q;
	end

	// current position
	logic [COL_W-1:0]   c;
	logic [ROW_W-1:0]   r;
	logic [LINE_AW-1:0] dx;
	logic [ROW_W-2:0]   dy;
	logic               last_col, last_row, pair, done, emit;
	logic               row_end, image_end;
	logic [PIX_W-1:0]   left, right;

	always_comb begin
		if (SRC_W_W'(col_q) >= ew || SRC_H_W'(row_q) >= eh) begin
			c = '0;
			r = '0;
		end else begin
			c = col_q;
			r = row_q;
		end
		dx = c[COL_W-1:1];
		dy = r[ROW_W-1:1];
		last_col = (SRC_W_W'(c) + SRC_W_W'(1)) == ew;
		last_row = (SRC_H_W'(r) + SRC_H_W'(1)) == eh;
		if (!c[0]) begin
			left  = s_tdata;
			right = s_tdata;
			pair  = last_col;
		end else begin
			left  = held_q;
			right = s_tdata;
			pair  = 1'b1;
		end
		done = pair && (r[0] || last_row);
		emit = done && (DST_W_W'(dx) < dw) && (DST_H_W'(dy) < dh);
		row_end = (DST_W_W'(dx) + DST_W_W'(1)) == dw;
		image_end = row_end && ((DST_H_W'(dy) + DST_H_W'(1)) == dh);
	end

	// pipeline control
	logic advance, accept;
	logic valid_s1;
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// line ram: written on even rows, read on odd rows, never both at once
	logic                 ram_we, ram_re;
	logic [2*PIX_W-1:0]   ram_rdata;
	assign ram_we = accept && pair && !r[0];
	assign ram_re = accept && pair && r[0];

	mr2_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dx),
		.wdata ({right, left}),
		.re    (ram_re),
		.raddr (dx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_W_W'(2);
			src_height_q <= SRC_H_W'(2);
			dst_width_q  <= DST_W_W'(1);
			dst_height_q <= DST_H_W'(1);
			fcfg_q.mode   <= FILT_BOX;
			fcfg_q.cutoff <= ALPHA_W'(128);
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:    src_width_q  <= cfg_data[SRC_W_W-1:0];
				REG_SRC_HEIGHT:   src_height_q <= cfg_data[SRC_H_W-1:0];
				REG_DST_WIDTH:    dst_width_q  <= cfg_data[DST_W_W-1:0];
				REG_DST_HEIGHT:   dst_height_q <= cfg_data[DST_H_W-1:0];
				REG_FILTER_MODE:  fcfg_q.mode   <= cfg_data[MODE_W-1:0];
				REG_ALPHA_CUTOFF: fcfg_q.cutoff <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
			// geometry writes restart the frame
			if (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
			    cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (accept) begin
			if (!c[0]) begin
				held_q <= s_tdata;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r + ROW_W'(1);
			end else begin
				col_q <= c + COL_W'(1);
				row_q <= r;
			end
		end
	end

	// read stage
	logic [PIX_W-1:0] left_s1, right_s1;
	logic             from_ram_s1, row_end_s1, image_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1      <= left;
			right_s1     <= right;
			from_ram_s1  <= r[0];
			row_end_s1   <= row_end;
			image_end_s1 <= image_end;
		end
	end

	quad_t            samples;
	logic [PIX_W-1:0] filt_result;

	always_comb begin
		if (from_ram_s1) begin
			samples[0] = ram_rdata[PIX_W-1:0];
			samples[1] = ram_rdata[2*PIX_W-1:PIX_W];
		end else begin
			samples[0] = left_s1;
			samples[1] = right_s1;
		end
		samples[2] = left_s1;
		samples[3] = right_s1;
	end

	mr2_filter u_filter (
		.samples (samples),
		.cfg     (fcfg_q),
		.result  (filt_result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= filt_result;
			m_tlast <= row_end_s1;
			m_tuser <= image_end_s1;
		end
	end

`ifndef SYNTHESIS
	a_ram_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line ram read and write in the same cycle");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		SRC_W_W'(col_q) < ew && SRC_H_W'(row_q) < eh)
		else $error("source position outside the image");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("read stage item lost during stall");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input blocked with room in the pipeline");

	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end without row end");
`endif

endmodule
`default_nettype wire

// ----- bench/mip_reduce_2x2_test.sv -----
// self-checking stream testbench for the 2x2 mipmap reducer
`timescale 1ns / 100ps
module mip_reduce_2x2_test;
	import mr2_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int LATENCY_PAD    = 8;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_ITEMS   = 900;
	localparam int LARGE_ITEMS    = 256;

	// codes the block must accept and ignore or treat as box
	localparam logic [MODE_W-1:0]    FILT_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] rgba;
		logic             row_end;
		logic             image_end;
	} dst_pix_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;  // pixel_rgba
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;         // result_rgba
	logic                  m_tlast;         // row_end
	logic                  m_tuser;         // image_end
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SRC_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	mip_reduce_2x2 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the registers, at their reset values
	int unsigned      geo_src_w  = 2;
	int unsigned      geo_src_h  = 2;
	int unsigned      geo_dst_w  = 1;
	int unsigned      geo_dst_h  = 1;
	logic [MODE_W-1:0]  filt_sel   = FILT_BOX;
	logic [ALPHA_W-1:0] opaque_min = 8'd128;

	// predictor state
	logic [63:0]      top_pairs [0:LINE_DEPTH-1];
	logic [PIX_W-1:0] held_left = '0;
	int unsigned      col_pos   = 0;
	int unsigned      row_pos   = 0;

	dst_pix_t dst_pix_q [$];
	dst_pix_t got_pix;
	dst_pix_t want_pix;

	int error_count  = 0;
	int results_seen = 0;
	int pixels_sent  = 0;
	int writes_done  = 0;
	int cycle_count  = 0;
	int burst_left   = 0;
	int gap_len      = 0;

	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_left  = 0;
	logic        holdoff_on    = 1'b0;
	event        holdoff_go;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				dst_pix_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: ready follows a random 16-bit pattern, redrawn whenever pattern_left runs out
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hFFFF;
				1: ready_pattern = ($urandom() & $urandom()) | 16'h0001;
				default: ready_pattern = $urandom();
			endcase
			pattern_left = 64;
		end
		pattern_left--;
		m_tready <= !holdoff_on && ready_pattern[pattern_left % 16];
	end

	always begin
		@(holdoff_go);
		holdoff_on <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		holdoff_on <= 1'b0;
	end

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] box_avg(input quad_t q);
		logic [PIX_W-1:0] r;
		logic [9:0]       sum;
		for (int c = 0; c < 4; c++) begin
			sum = 10'(q[0][8*c +: 8]) + 10'(q[1][8*c +: 8])
				+ 10'(q[2][8*c +: 8]) + 10'(q[3][8*c +: 8]);
			r[8*c +: 8] = sum[9:2];
		end
		return r;
	endfunction

	// earliest sample wins a tie since only a strictly larger count replaces it
	function automatic logic [PIX_W-1:0] most_frequent(input quad_t q);
		int best;
		int best_n;
		int n;
		best   = 0;
		best_n = 1;
		for (int i = 0; i < 4; i++) begin
			n = 1;
			for (int j = i + 1; j < 4; j++)
				if (q[i] == q[j]) n++;
			if (n > best_n) begin
				best_n = n;
				best   = i;
			end
		end
		return q[best];
	endfunction

	function automatic logic [PIX_W-1:0] alpha_cut(input quad_t q, input logic [7:0] cutoff);
		int         best;
		logic [7:0] best_a;
		logic       opaque;
		best   = 0;
		best_a = q[0][31:24];
		opaque = best_a >= cutoff;
		for (int i = 1; i < 4; i++) begin
			if (q[i][31:24] > best_a) begin
				best_a = q[i][31:24];
				best   = i;
			end
			if (q[i][31:24] >= cutoff) opaque = 1'b1;
		end
		if (!opaque) return '0;
		return {8'hFF, q[best][23:0]};
	endfunction

	function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
		int unsigned      ew, eh, dw, dh, dx, dy;
		logic             last_col, last_row, pair_ready, block_done;
		logic [PIX_W-1:0] pix_l, pix_r;
		quad_t            q;
		dst_pix_t         res;
		ew = clamp_size(geo_src_w, MAX_WIDTH);
		eh = clamp_size(geo_src_h, MAX_HEIGHT);
		dw = clamp_size(geo_dst_w, (ew + 1) / 2);
		dh = clamp_size(geo_dst_h, (eh + 1) / 2);
		if (col_pos >= ew || row_pos >= eh) begin
			col_pos = 0;
			row_pos = 0;
		end
		dx         = col_pos / 2;
		dy         = row_pos / 2;
		last_col   = (col_pos + 1 == ew);
		last_row   = (row_pos + 1 == eh);
		pair_ready = 1'b0;
		block_done = 1'b0;
		pix_l      = held_left;
		pix_r      = pix;
		if (col_pos % 2 == 0) begin
			held_left = pix;
			// odd width: the last column stands in for its missing neighbor
			if (last_col) begin
				pix_l      = pix;
				pair_ready = 1'b1;
			end
		end else begin
			pair_ready = 1'b1;
		end
		if (pair_ready) begin
			if (row_pos % 2 == 0) begin
				top_pairs[dx] = {pix_r, pix_l};
				if (last_row) begin
					q          = {pix_r, pix_l, pix_r, pix_l};
					block_done = 1'b1;
				end
			end else begin
				q          = {pix_r, pix_l, top_pairs[dx][63:32], top_pairs[dx][31:0]};
				block_done = 1'b1;
			end
		end
		if (block_done && dx < dw && dy < dh) begin
			case (filt_sel)
				FILT_MODE:   res.rgba = most_frequent(q);
				FILT_CUTOUT: res.rgba = alpha_cut(q, opaque_min);
				default:     res.rgba = box_avg(q);
			endcase
			res.row_end   = (dx + 1 == dw);
			res.image_end = (dx + 1 == dw) && (dy + 1 == dh);
			dst_pix_q.push_back(res);
		end
		col_pos++;
		if (col_pos >= ew) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= eh) row_pos = 0;
		end
	endfunction

	function automatic void log_error(input string what, input dst_pix_t want,
			input dst_pix_t got);
		error_count++;
		if (error_count <= 10)
			$display("%0t %s: expected %08h/%0b/%0b got %08h/%0b/%0b (rgba/row/image)",
				$realtime, what, want.rgba, want.row_end, want.image_end,
				got.rgba, got.row_end, got.image_end);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_pix = '{m_tdata, m_tlast, m_tuser};
			results_seen++;
			if (dst_pix_q.size() == 0) begin
				log_error("result with nothing due", '0, got_pix);
			end else begin
				want_pix = dst_pix_q.pop_front();
				if (got_pix.rgba !== want_pix.rgba || got_pix.row_end !== want_pix.row_end ||
						got_pix.image_end !== want_pix.image_end)
					log_error("mismatch", want_pix, got_pix);
			end
		end
	end

	// one source item, sent in bursts with random gaps between them
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		if (burst_left == 0) begin
			gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if (gap_len != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_pixel(pix);
		pixels_sent++;
	endtask

	task automatic send_quad(input logic [PIX_W-1:0] tl, tr, bl, br);
		send_pixel(tl);
		send_pixel(tr);
		send_pixel(bl);
		send_pixel(br);
	endtask

	// blocks that swallow an item without a result may still be busy
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (dst_pix_q.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:    geo_src_w  = data[SRC_W_W-1:0];
			REG_SRC_HEIGHT:   geo_src_h  = data[SRC_H_W-1:0];
			REG_DST_WIDTH:    geo_dst_w  = data[DST_W_W-1:0];
			REG_DST_HEIGHT:   geo_dst_h  = data[DST_H_W-1:0];
			REG_FILTER_MODE:  filt_sel   = data[MODE_W-1:0];
			REG_ALPHA_CUTOFF: opaque_min = data[ALPHA_W-1:0];
			default: ;
		endcase
		// any geometry write starts a new frame
		if (idx <= REG_DST_HEIGHT) begin
			col_pos = 0;
			row_pos = 0;
		end
		writes_done++;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned sw, sh, dw, dh);
		wait_idle();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
	endtask

	task automatic set_filter(input logic [MODE_W-1:0] sel, input logic [ALPHA_W-1:0] cutoff);
		wait_idle();
		write_reg(REG_FILTER_MODE, sel);
		write_reg(REG_ALPHA_CUTOFF, cutoff);
	endtask

	// default 2x2 box setup straight out of reset, channel extremes
	task automatic test_reset_values();
		send_quad(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_filter_rules();
		set_geometry(2, 2, 1, 1);
		set_filter(FILT_MODE, 8'd128);
		send_quad(32'h1122_3344, 32'h5566_7788, 32'h5566_7788, 32'h1122_3344);
		send_quad(32'h0102_0304, 32'hA0B0_C0D0, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
		set_filter(FILT_CUTOUT, 8'd128);
		send_quad(32'h7F11_2233, 32'h0044_5566, 32'h7F77_8899, 32'h01AA_BBCC);
		send_quad(32'h8011_2233, 32'hF044_5566, 32'hF077_8899, 32'h10AA_BBCC);
		set_filter(FILT_UNUSED, 8'd255);
		send_quad($urandom(), $urandom(), $urandom(), $urandom());
	endtask

	task automatic test_edge_geometry();
		// odd edges, oversized destination saturates to 2x2
		set_geometry(3, 3, 4095, 4095);
		set_filter(FILT_BOX, 8'd128);
		repeat (9) send_pixel($urandom());
		// zero sizes act as one: every item is a whole image
		set_geometry(0, 0, 0, 0);
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, '1);
		repeat (3) send_pixel($urandom());
		// blocks outside the destination give nothing
		set_geometry(4, 4, 1, 1);
		repeat (16) send_pixel($urandom());
		// broken frame, then restart by a geometry write
		set_geometry(4, 4, 2, 2);
		repeat (6) send_pixel($urandom());
		set_geometry(4, 4, 2, 2);
		repeat (16) send_pixel($urandom());
	endtask

	// register maxima clamp to the widest and tallest images; the start of each is checked
	task automatic test_largest_sizes();
		set_geometry(4095, 1, 2047, 1);
		repeat (LARGE_ITEMS) send_pixel($urandom());
		set_geometry(1, 8191, 1, 4095);
		repeat (LARGE_ITEMS) send_pixel($urandom());
	endtask

	task automatic test_backpressure();
		set_geometry(16, 16, 8, 8);
		set_filter(FILT_CUTOUT, 8'd64);
		->holdoff_go;
		repeat (256) send_pixel($urandom());
	endtask

	task automatic test_random_frames();
		int unsigned      sw, sh, area, count;
		int               start_count;
		logic [PIX_W-1:0] palette [4];
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_ITEMS) begin
			sw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 48) : $urandom_range(1, 10);
			sh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
			set_geometry(sw, sh, $urandom_range(0, sw / 2 + 2), $urandom_range(0, sh / 2 + 2));
			write_reg(REG_FILTER_MODE, $urandom());
			case ($urandom_range(0, 3))
				0: write_reg(REG_ALPHA_CUTOFF, 0);
				1: write_reg(REG_ALPHA_CUTOFF, 255);
				default: write_reg(REG_ALPHA_CUTOFF, $urandom());
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), $urandom());
			// a small palette makes repeated values and alpha ties likely
			foreach (palette[i]) palette[i] = $urandom();
			area  = clamp_size(sw, MAX_WIDTH) * clamp_size(sh, MAX_HEIGHT);
			count = area * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 2 * area);
			repeat (count)
				send_pixel(($urandom_range(0, 2) == 0) ? $urandom()
					: palette[$urandom_range(0, 3)]);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_filter_rules();
		test_edge_geometry();
		test_largest_sizes();
		test_backpressure();
		test_random_frames();
		wait_idle();
		$display("checked %0d destination pixels from %0d source items, %0d register writes",
			results_seen, pixels_sent, writes_done);
		$display("all filter modes, odd edges, clamped sizes, frame restarts, long output stall");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", error_count);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
